/* hw/rtl/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_PRESS_C = 3'd3;
    localparam logic [2:0] CFG_HUM     = 3'd4;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COEF48_W    = 48;

    // One quotient bit per divider stage
    localparam int DIV_STEPS   = 64;
    // Stages: 9 ahead of the divider, DIV_STEPS divider stages, 5 after it
    localparam int PIPE_DEPTH  = DIV_STEPS + 14;
    // Side line for temperature and humidity: stage 11 up to the stage ahead of the output register
    localparam int SIDE_LEN    = DIV_STEPS + 3;

    localparam logic [31:0] HUM_CLAMP_HIGH = 32'd419430400;
    localparam logic [63:0] PRESS_MAX      = 64'd1048575;

    typedef struct packed {
        logic [19:0] adc_pressure;
        logic [19:0] adc_temperature;
        logic [15:0] adc_humidity;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [19:0]        pressure;
        logic               pressure_valid;
        logic [16:0]        humidity;
    } t_out;

endpackage

/* hw/rtl/barometric_sensor_compensation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_top
// Fixed-point compensation of raw pressure, temperature and humidity samples.
// ----------------------------------------------------------------------------
// Usage:
//   Load the calibration coefficients through i_cfg_we / i_cfg_idx /
//   i_cfg_data while no sample is in flight. Present a raw sample set on
//   i_in with i_start high; it is taken at that edge whenever o_busy is low,
//   and o_busy stays low, so a new beat may enter on every clock.
//   Each beat returns exactly one result on o_result, marked by o_done for
//   one cycle, once it has passed through all PIPE_DEPTH stages.
//   Throughput is one beat per cycle. The pipeline depth is set by the signed
//   64-bit divider, which resolves one quotient bit per stage (64 stages),
//   plus 9 stages of coefficient arithmetic ahead of it and 5 after it.
//   Reset clears all in-flight valid bits and sets every coefficient
//   register to zero. The receiver cannot stall, so results simply stream
//   out in input order.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  bsc_pkg::t_in                   i_in,
    output logic                           o_done,
    output bsc_pkg::t_out                  o_result,
    input  logic                           i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NS = bsc_pkg::DIV_STEPS;
    localparam int SIDE_LAST = bsc_pkg::SIDE_LEN - 1;

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic [bsc_pkg::COEF48_W-1:0] r_temp_c, r_pa_c, r_pb_c, r_pc_c;
    logic [63:0]                  r_hum_c;

    // Write the addressed register; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_c <= '0;
            r_pa_c   <= '0;
            r_pb_c   <= '0;
            r_pc_c   <= '0;
            r_hum_c  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsc_pkg::CFG_TEMP:    r_temp_c <= i_cfg_data[bsc_pkg::COEF48_W-1:0];
                bsc_pkg::CFG_PRESS_A: r_pa_c   <= i_cfg_data[bsc_pkg::COEF48_W-1:0];
                bsc_pkg::CFG_PRESS_B: r_pb_c   <= i_cfg_data[bsc_pkg::COEF48_W-1:0];
                bsc_pkg::CFG_PRESS_C: r_pc_c   <= i_cfg_data[bsc_pkg::COEF48_W-1:0];
                bsc_pkg::CFG_HUM:     r_hum_c  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic [11:0]        h4, h5;
    logic [7:0]         h6;
    assign t1 = r_temp_c[15:0];
    assign t2 = $signed(r_temp_c[31:16]);
    assign t3 = $signed(r_temp_c[47:32]);
    assign p1 = r_pa_c[15:0];
    assign p2 = $signed(r_pa_c[31:16]);
    assign p3 = $signed(r_pa_c[47:32]);
    assign p4 = $signed(r_pb_c[15:0]);
    assign p5 = $signed(r_pb_c[31:16]);
    assign p6 = $signed(r_pb_c[47:32]);
    assign p7 = $signed(r_pc_c[15:0]);
    assign p8 = $signed(r_pc_c[31:16]);
    assign p9 = $signed(r_pc_c[47:32]);
    assign h1 = r_hum_c[7:0];
    assign h2 = $signed(r_hum_c[23:8]);
    assign h3 = r_hum_c[31:24];
    assign h4 = r_hum_c[43:32];
    assign h5 = r_hum_c[55:44];
    assign h6 = r_hum_c[63:56];

    // Never holds off a beat
    assign o_busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid line
    // ------------------------------------------------------------------
    logic r_vld [0:bsc_pkg::PIPE_DEPTH-1];

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bsc_pkg::PIPE_DEPTH; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
            for (int k = 1; k < bsc_pkg::PIPE_DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    assign o_done = r_vld[bsc_pkg::PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // Stage 1: temperature products
    // ------------------------------------------------------------------
    logic [31:0] s1_da, s1_db;
    logic [63:0] s1_tam, s1_dbsq;
    logic [31:0] r1_tam, r1_dbsq;
    logic [19:0] r_rp_d [0:5];
    logic [15:0] r_rh_d [0:3];

    assign s1_da   = {15'd0, i_in.adc_temperature[19:3]} - {15'd0, t1, 1'b0};
    assign s1_db   = {16'd0, i_in.adc_temperature[19:4]} - {16'd0, t1};
    assign s1_tam  = s1_da * {{16{t2[15]}}, t2};
    assign s1_dbsq = s1_db * s1_db;

    always_ff @(posedge i_clk) begin
        r1_tam    <= s1_tam[31:0];
        r1_dbsq   <= s1_dbsq[31:0];
        r_rp_d[0] <= i_in.adc_pressure;
        r_rh_d[0] <= i_in.adc_humidity;
        for (int k = 1; k < 6; k++) r_rp_d[k] <= r_rp_d[k-1];
        for (int k = 1; k < 4; k++) r_rh_d[k] <= r_rh_d[k-1];
    end

    // ------------------------------------------------------------------
    // Stage 2: second temperature product
    // ------------------------------------------------------------------
    logic [31:0] s2_tbin;
    logic [63:0] s2_tbm;
    logic [31:0] r2_ta, r2_tbm;

    assign s2_tbin = 32'($signed(r1_dbsq) >>> 12);
    assign s2_tbm  = s2_tbin * {{16{t3[15]}}, t3};

    always_ff @(posedge i_clk) begin
        r2_ta  <= 32'($signed(r1_tam) >>> 11);
        r2_tbm <= s2_tbm[31:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: fine temperature
    // ------------------------------------------------------------------
    logic [31:0] r3_fine;

    always_ff @(posedge i_clk) begin
        r3_fine <= r2_ta + 32'($signed(r2_tbm) >>> 14);
    end

    // ------------------------------------------------------------------
    // Stage 4: temperature result, first pressure and humidity products
    // ------------------------------------------------------------------
    logic signed [35:0] s4_f36, s4_tf, s4_tc;
    logic signed [15:0] s4_temp;
    logic signed [33:0] s4_pa;
    logic signed [67:0] s4_pasq;
    logic signed [49:0] s4_pap5, s4_pap2;
    logic [31:0]        s4_hd;
    logic [63:0]        s4_h5hd, s4_hyp, s4_hzp;
    logic [63:0]        r4_pasq, r4_pap5, r4_pap2;
    logic [31:0]        r4_h5hd, r4_hyp, r4_hzp;
    logic signed [15:0] r_tmp_d [0:6];

    assign s4_f36 = {{4{r3_fine[31]}}, r3_fine};
    assign s4_tf  = s4_f36 * 36'sd5 + 36'sd128;
    assign s4_tc  = s4_tf >>> 8;

    // Saturate temperature to 16 bits
    always_comb begin
        if (s4_tc < -36'sd32768) begin
            s4_temp = 16'sh8000;
        end else if (s4_tc > 36'sd32767) begin
            s4_temp = 16'sh7FFF;
        end else begin
            s4_temp = s4_tc[15:0];
        end
    end

    assign s4_pa   = {{2{r3_fine[31]}}, r3_fine} - 34'sd128000;
    assign s4_pasq = s4_pa * s4_pa;
    assign s4_pap5 = s4_pa * p5;
    assign s4_pap2 = s4_pa * p2;

    assign s4_hd   = r3_fine - 32'd76800;
    assign s4_h5hd = {{20{h5[11]}}, h5} * s4_hd;
    assign s4_hyp  = s4_hd * {{24{h6[7]}}, h6};
    assign s4_hzp  = s4_hd * {24'd0, h3};

    always_ff @(posedge i_clk) begin
        r4_pasq    <= s4_pasq[63:0];
        r4_pap5    <= 64'(s4_pap5);
        r4_pap2    <= 64'(s4_pap2);
        r4_h5hd    <= s4_h5hd[31:0];
        r4_hyp     <= s4_hyp[31:0];
        r4_hzp     <= s4_hzp[31:0];
        r_tmp_d[0] <= s4_temp;
        for (int k = 1; k < 7; k++) r_tmp_d[k] <= r_tmp_d[k-1];
    end

    // ------------------------------------------------------------------
    // Stage 5: cubic pressure products, humidity terms
    // ------------------------------------------------------------------
    logic signed [79:0] s5_pbm, s5_pam;
    logic [31:0]        s5_hxs;
    logic [63:0]        r5_pbm, r5_pam, r5_pap5, r5_pap2;
    logic [31:0]        r5_hx, r5_hy, r5_hz;

    assign s5_pbm = $signed(r4_pasq) * p6;
    assign s5_pam = $signed(r4_pasq) * p3;
    assign s5_hxs = {2'd0, r_rh_d[3], 14'd0} - {h4, 20'd0} - r4_h5hd + 32'd16384;

    always_ff @(posedge i_clk) begin
        r5_pbm  <= s5_pbm[63:0];
        r5_pam  <= s5_pam[63:0];
        r5_pap5 <= r4_pap5;
        r5_pap2 <= r4_pap2;
        r5_hx   <= 32'($signed(s5_hxs) >>> 15);
        r5_hy   <= 32'($signed(r4_hyp) >>> 10);
        r5_hz   <= 32'($signed(r4_hzp) >>> 11) + 32'd32768;
    end

    // ------------------------------------------------------------------
    // Stage 6: pressure sums, humidity product
    // ------------------------------------------------------------------
    logic [63:0] s6_hwp;
    logic [63:0] r6_pb, r6_pa1;
    logic [31:0] r6_hwp, r6_hx;

    assign s6_hwp = r5_hy * r5_hz;

    always_ff @(posedge i_clk) begin
        r6_pb  <= r5_pbm + {r5_pap5[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
        r6_pa1 <= 64'($signed(r5_pam) >>> 8) + {r5_pap2[51:0], 12'd0};
        r6_hwp <= s6_hwp[31:0];
        r6_hx  <= r5_hx;
    end

    // ------------------------------------------------------------------
    // Stage 7: divisor product, dividend base
    // ------------------------------------------------------------------
    logic [63:0] s7_x;
    logic [79:0] s7_pa2p;
    logic [20:0] s7_rpd;
    logic [31:0] s7_hw;
    logic [63:0] s7_hw2p;
    logic [63:0] r7_pa2p, r7_pq0;
    logic [31:0] r7_hw2p, r7_hx;

    assign s7_x    = r6_pa1 + 64'h0000_8000_0000_0000;
    assign s7_pa2p = s7_x * p1;
    assign s7_rpd  = 21'h10_0000 - {1'b0, r_rp_d[5]};
    assign s7_hw   = 32'($signed(r6_hwp) >>> 10) + 32'd2097152;
    assign s7_hw2p = s7_hw * {{16{h2[15]}}, h2};

    always_ff @(posedge i_clk) begin
        r7_pa2p <= s7_pa2p[63:0];
        r7_pq0  <= {12'd0, s7_rpd, 31'd0} - r6_pb;
        r7_hw2p <= s7_hw2p[31:0];
        r7_hx   <= r6_hx;
    end

    // ------------------------------------------------------------------
    // Stage 8: dividend and divisor, humidity product
    // ------------------------------------------------------------------
    logic [75:0] s8_num;
    logic [31:0] s8_hw, s8_hwr;
    logic [63:0] s8_hv;
    logic [63:0] r8_num, r8_den;
    logic [31:0] r8_hv;

    assign s8_num = r7_pq0 * 12'd3125;
    assign s8_hwr = r7_hw2p + 32'd8192;
    assign s8_hw  = 32'($signed(s8_hwr) >>> 14);
    assign s8_hv  = r7_hx * s8_hw;

    always_ff @(posedge i_clk) begin
        r8_num <= s8_num[63:0];
        r8_den <= 64'($signed(r7_pa2p) >>> 33);
        r8_hv  <= s8_hv[31:0];
    end

    // ------------------------------------------------------------------
    // Stage 9: divider operands (magnitudes), humidity square
    // ------------------------------------------------------------------
    logic [63:0] r_dv_rem  [0:NS];
    logic [63:0] r_dv_quo  [0:NS];
    logic [63:0] r_dv_md   [0:NS];
    logic        r_dv_neg  [0:NS];
    logic        r_dv_zero [0:NS];
    logic [31:0] s9_hq;
    logic [63:0] s9_hqsq;
    logic [31:0] r9_hqsq, r9_hv;

    assign s9_hq   = 32'($signed(r8_hv) >>> 15);
    assign s9_hqsq = s9_hq * s9_hq;

    always_ff @(posedge i_clk) begin
        r_dv_rem[0]  <= '0;
        r_dv_quo[0]  <= r8_num[63] ? (64'd0 - r8_num) : r8_num;
        r_dv_md[0]   <= r8_den[63] ? (64'd0 - r8_den) : r8_den;
        r_dv_neg[0]  <= r8_num[63] ^ r8_den[63];
        r_dv_zero[0] <= (r8_den == 64'd0);
        r9_hqsq      <= s9_hqsq[31:0];
        r9_hv        <= r8_hv;
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= NS; j++) begin : g_div
        logic [64:0] w_trial;
        logic [64:0] w_diff;
        logic        w_bit;

        assign w_trial = {r_dv_rem[j-1], r_dv_quo[j-1][63]};
        assign w_diff  = w_trial - {1'b0, r_dv_md[j-1]};
        assign w_bit   = !w_diff[64];

        always_ff @(posedge i_clk) begin
            r_dv_rem[j]  <= w_bit ? w_diff[63:0] : w_trial[63:0];
            r_dv_quo[j]  <= {r_dv_quo[j-1][62:0], w_bit};
            r_dv_md[j]   <= r_dv_md[j-1];
            r_dv_neg[j]  <= r_dv_neg[j-1];
            r_dv_zero[j] <= r_dv_zero[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 10 and 11: finish humidity, then hold it and the temperature beside the divider
    // ------------------------------------------------------------------
    logic [31:0] s10_hmin;
    logic [63:0] s10_hm;
    logic [31:0] r10_hm, r10_hv;
    logic [31:0] s11_hv;
    logic [31:0] s11_hc;
    logic signed [15:0] r_sd_temp [0:SIDE_LAST];
    logic [16:0]        r_sd_hum  [0:SIDE_LAST];

    assign s10_hmin = 32'($signed(r9_hqsq) >>> 7);
    assign s10_hm   = s10_hmin * {24'd0, h1};

    always_ff @(posedge i_clk) begin
        r10_hm <= s10_hm[31:0];
        r10_hv <= r9_hv;
    end

    assign s11_hv = r10_hv - 32'($signed(r10_hm) >>> 4);

    // Clamp humidity to 0..100 %RH in Q10.22
    always_comb begin
        if (s11_hv[31]) begin
            s11_hc = '0;
        end else if (s11_hv > bsc_pkg::HUM_CLAMP_HIGH) begin
            s11_hc = bsc_pkg::HUM_CLAMP_HIGH;
        end else begin
            s11_hc = s11_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd_temp[0] <= r_tmp_d[6];
        r_sd_hum[0]  <= s11_hc[28:12];
        for (int k = 1; k < bsc_pkg::SIDE_LEN; k++) begin
            r_sd_temp[k] <= r_sd_temp[k-1];
            r_sd_hum[k]  <= r_sd_hum[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Post 1: signed quotient
    // ------------------------------------------------------------------
    logic [63:0] r_q1;
    logic        r_z1;

    always_ff @(posedge i_clk) begin
        r_q1 <= r_dv_neg[NS] ? (64'd0 - r_dv_quo[NS]) : r_dv_quo[NS];
        r_z1 <= r_dv_zero[NS];
    end

    // ------------------------------------------------------------------
    // Post 2: P9 and P8 products
    // ------------------------------------------------------------------
    logic [63:0]        s2p_s13;
    logic signed [79:0] s2p_a, s2p_cb;
    logic [63:0]        r_q2, r_s13_2, r_a2, r_cb2;
    logic               r_z2;

    assign s2p_s13 = 64'($signed(r_q1) >>> 13);
    assign s2p_a   = $signed(s2p_s13) * p9;
    assign s2p_cb  = $signed(r_q1) * p8;

    always_ff @(posedge i_clk) begin
        r_q2    <= r_q1;
        r_s13_2 <= s2p_s13;
        r_a2    <= s2p_a[63:0];
        r_cb2   <= s2p_cb[63:0];
        r_z2    <= r_z1;
    end

    // ------------------------------------------------------------------
    // Post 3: low 64 bits of a * s13 as partial products
    // ------------------------------------------------------------------
    logic [63:0] s3p_ll, s3p_m1, s3p_m2;
    logic [63:0] r_q3, r_cb3, r_ll3;
    logic [31:0] r_x3;
    logic        r_z3;

    assign s3p_ll = r_a2[31:0] * r_s13_2[31:0];
    assign s3p_m1 = r_a2[63:32] * r_s13_2[31:0];
    assign s3p_m2 = r_a2[31:0] * r_s13_2[63:32];

    always_ff @(posedge i_clk) begin
        r_q3  <= r_q2;
        r_cb3 <= r_cb2;
        r_ll3 <= s3p_ll;
        r_x3  <= s3p_m1[31:0] + s3p_m2[31:0];
        r_z3  <= r_z2;
    end

    // ------------------------------------------------------------------
    // Post 4: correction terms
    // ------------------------------------------------------------------
    logic [63:0] s4p_cap;
    logic [63:0] r_q4, r_ca4, r_cb4;
    logic        r_z4;

    assign s4p_cap = r_ll3 + {r_x3, 32'd0};

    always_ff @(posedge i_clk) begin
        r_q4  <= r_q3;
        r_ca4 <= 64'($signed(s4p_cap) >>> 25);
        r_cb4 <= 64'($signed(r_cb3) >>> 19);
        r_z4  <= r_z3;
    end

    // ------------------------------------------------------------------
    // Post 5: final pressure, saturate, output register
    // ------------------------------------------------------------------
    logic [63:0] s5p_sum, s5p_pq, s5p_pv;
    logic [19:0] s5p_pres;

    assign s5p_sum = r_q4 + r_ca4 + r_cb4;
    assign s5p_pq  = 64'($signed(s5p_sum) >>> 8) + {{44{p7[15]}}, p7, 4'd0};
    assign s5p_pv  = 64'($signed(s5p_pq) >>> 8);

    // Saturate pressure to 0..2^20-1; zero divisor gives zero
    always_comb begin
        if (r_z4 || s5p_pv[63]) begin
            s5p_pres = '0;
        end else if (s5p_pv > bsc_pkg::PRESS_MAX) begin
            s5p_pres = '1;
        end else begin
            s5p_pres = s5p_pv[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.temperature    <= r_sd_temp[SIDE_LAST];
        o_result.humidity       <= r_sd_hum[SIDE_LAST];
        o_result.pressure       <= s5p_pres;
        o_result.pressure_valid <= !r_z4;
    end

endmodule

/* sim/tb_barometric_sensor_compensation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation_top
// Self-checking bench for the sensor compensation pipeline. Sample sets are
// sent in random bursts under several coefficient settings (reset values,
// typical calibration, extremes, random); each result is compared field by
// field with a bit-accurate prediction kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation_top;

    // Register indexes that decode to nothing; writes to them must be dropped
    localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
    localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO  = 3'd5;
    localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_MID = 3'd6;
    localparam int SETTLE_CYCLES = bsc_pkg::PIPE_DEPTH + 8;

    // Typical calibration set
    localparam logic [63:0] TYP_TEMP = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PA   = {16'd0, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PB   = {16'd0, 16'hFFF9, 16'd140, 16'd2855};
    localparam logic [63:0] TYP_PC   = {16'd0, 16'd6000, 16'hC6F8, 16'd15500};
    localparam logic [63:0] TYP_HUM  = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    // ------------------------------------------------------------------------
    // Scoreboard: coefficient copy, predictor and queue of expected results
    // ------------------------------------------------------------------------
    class compensation_scoreboard;
        bit [63:0]      temp_c, press_a, press_b, press_c, hum_c;
        bsc_pkg::t_out  pending_results[$];
        int             mismatches;

        function new();
            temp_c = '0; press_a = '0; press_b = '0; press_c = '0; hum_c = '0;
            mismatches = 0;
        endfunction

        function void set_coeff(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                bsc_pkg::CFG_TEMP:    temp_c  = data & 64'hFFFF_FFFF_FFFF;
                bsc_pkg::CFG_PRESS_A: press_a = data & 64'hFFFF_FFFF_FFFF;
                bsc_pkg::CFG_PRESS_B: press_b = data & 64'hFFFF_FFFF_FFFF;
                bsc_pkg::CFG_PRESS_C: press_c = data & 64'hFFFF_FFFF_FFFF;
                bsc_pkg::CFG_HUM:     hum_c   = data;
                default: ;
            endcase
        endfunction

        function bit [31:0] sra32(bit [31:0] v, int n);
            return $signed(v) >>> n;
        endfunction

        function bit [63:0] sra64(bit [63:0] v, int n);
            return $signed(v) >>> n;
        endfunction

        // Signed divide truncating toward zero; MIN / -1 wraps to MIN
        function bit [63:0] div_s64(bit [63:0] n, bit [63:0] d);
            bit [63:0] mn, md, q;
            mn = n[63] ? -n : n;
            md = d[63] ? -d : d;
            q  = mn / md;
            return (n[63] ^ d[63]) ? -q : q;
        endfunction

        function bsc_pkg::t_out compensate(bsc_pkg::t_in s);
            bit [31:0] rp, rt, rh, t1, t2, t3, da, ta, db, tb, fine;
            bit [63:0] fine64, tcs;
            longint    tcv, pv;
            bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, pa, pb, pq, s13, ca, cb;
            bit [31:0] h1, h2, h3, h4, h5, h6, hd, hx, hy, hz, hw, hv, hq;
            int        hs;
            bsc_pkg::t_out r;
            rp = {12'd0, s.adc_pressure};
            rt = {12'd0, s.adc_temperature};
            rh = {16'd0, s.adc_humidity};

            // fine temperature and degC
            t1 = {16'd0, temp_c[15:0]};
            t2 = {{16{temp_c[31]}}, temp_c[31:16]};
            t3 = {{16{temp_c[47]}}, temp_c[47:32]};
            da = (rt >> 3) - (t1 << 1);
            ta = sra32(da * t2, 11);
            db = (rt >> 4) - t1;
            tb = sra32(sra32(db * db, 12) * t3, 14);
            fine = ta + tb;
            fine64 = {{32{fine[31]}}, fine};
            tcs = sra64(fine64 * 64'd5 + 64'd128, 8);
            tcv = $signed(tcs);
            if (tcv < -64'sd32768) tcv = -64'sd32768;
            if (tcv > 64'sd32767) tcv = 64'sd32767;
            r.temperature = tcv[15:0];

            // pressure
            p1 = {48'd0, press_a[15:0]};
            p2 = {{48{press_a[31]}}, press_a[31:16]};
            p3 = {{48{press_a[47]}}, press_a[47:32]};
            p4 = {{48{press_b[15]}}, press_b[15:0]};
            p5 = {{48{press_b[31]}}, press_b[31:16]};
            p6 = {{48{press_b[47]}}, press_b[47:32]};
            p7 = {{48{press_c[15]}}, press_c[15:0]};
            p8 = {{48{press_c[31]}}, press_c[31:16]};
            p9 = {{48{press_c[47]}}, press_c[47:32]};
            pa = fine64 - 64'd128000;
            pb = pa * pa * p6;
            pb = pb + ((pa * p5) << 17);
            pb = pb + (p4 << 35);
            pa = sra64(pa * pa * p3, 8) + ((pa * p2) << 12);
            pa = sra64(((64'd1 << 47) + pa) * p1, 33);
            r.pressure = '0;
            r.pressure_valid = 1'b0;
            if (pa != 64'd0) begin
                pq = ((64'd1048576 - {32'd0, rp}) << 31) - pb;
                pq = div_s64(pq * 64'd3125, pa);
                s13 = sra64(pq, 13);
                ca = sra64(p9 * s13 * s13, 25);
                cb = sra64(p8 * pq, 19);
                pq = sra64(pq + ca + cb, 8) + (p7 << 4);
                pv = $signed(sra64(pq, 8));
                if (pv < 64'sd0) pv = 64'sd0;
                if (pv > 64'sd1048575) pv = 64'sd1048575;
                r.pressure = pv[19:0];
                r.pressure_valid = 1'b1;
            end

            // humidity
            h1 = {24'd0, hum_c[7:0]};
            h2 = {{16{hum_c[23]}}, hum_c[23:8]};
            h3 = {24'd0, hum_c[31:24]};
            h4 = {{20{hum_c[43]}}, hum_c[43:32]};
            h5 = {{20{hum_c[55]}}, hum_c[55:44]};
            h6 = {{24{hum_c[63]}}, hum_c[63:56]};
            hd = fine - 32'd76800;
            hx = sra32((rh << 14) - (h4 << 20) - h5 * hd + 32'd16384, 15);
            hy = sra32(hd * h6, 10);
            hz = sra32(hd * h3, 11) + 32'd32768;
            hw = sra32(hy * hz, 10) + 32'd2097152;
            hw = sra32(hw * h2 + 32'd8192, 14);
            hv = hx * hw;
            hq = sra32(hv, 15);
            hv = hv - sra32(sra32(hq * hq, 7) * h1, 4);
            hs = $signed(hv);
            if (hs < 0) hs = 0;
            if (hs > $signed(bsc_pkg::HUM_CLAMP_HIGH)) hs = $signed(bsc_pkg::HUM_CLAMP_HIGH);
            r.humidity = 17'(hs >>> 12);
            return r;
        endfunction

        function void note_sample(bsc_pkg::t_in s);
            pending_results.push_back(compensate(s));
        endfunction

        function void check_result(bsc_pkg::t_out got);
            bsc_pkg::t_out want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.temperature !== want.temperature || got.pressure !== want.pressure ||
                got.pressure_valid !== want.pressure_valid ||
                got.humidity !== want.humidity) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: temp %0d/%0d press %0d/%0d valid %0b/%0b hum %0d/%0d",
                             $signed(want.temperature), $signed(got.temperature),
                             want.pressure, got.pressure, want.pressure_valid,
                             got.pressure_valid, want.humidity, got.humidity);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    bsc_pkg::t_in                   i_in;
    logic                           o_done;
    bsc_pkg::t_out                  o_result;
    logic                           i_cfg_we;
    logic [bsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bsc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    compensation_scoreboard sb = new();
    int burst_left = 0;

    barometric_sensor_compensation_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Note every accepted beat, check every result beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            sb.note_sample(i_in);
        if (i_rst_n && o_done)
            sb.check_result(o_result);
    end

    task automatic write_coeff(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_coeff(idx, data);
        @(posedge i_clk);
    endtask

    task automatic load_coeffs(logic [63:0] t, logic [63:0] a, logic [63:0] b,
                               logic [63:0] c, logic [63:0] h);
        write_coeff(bsc_pkg::CFG_TEMP, t);
        write_coeff(bsc_pkg::CFG_PRESS_A, a);
        write_coeff(bsc_pkg::CFG_PRESS_B, b);
        write_coeff(bsc_pkg::CFG_PRESS_C, c);
        write_coeff(bsc_pkg::CFG_HUM, h);
    endtask

    // Send one beat; open a new burst after a random gap when the last one ran out
    task automatic send_sample(bsc_pkg::t_in s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_start <= 1'b1;
        i_in    <= s;
        do @(posedge i_clk); while (o_busy);
        burst_left--;
    endtask

    // Hold off until every expected result has come back, then let the pipe settle
    task automatic drain();
        i_start <= 1'b0;
        burst_left = 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic bsc_pkg::t_in rand_sample();
        bsc_pkg::t_in s;
        if ($urandom_range(0, 9) < 7) begin
            s.adc_pressure    = 20'(32'd415148 + $urandom_range(0, 200000) - 32'd100000);
            s.adc_temperature = 20'(32'd519888 + $urandom_range(0, 200000) - 32'd100000);
            s.adc_humidity    = 16'(32'd30000 + $urandom_range(0, 30000) - 32'd15000);
        end else begin
            s.adc_pressure    = 20'($urandom);
            s.adc_temperature = 20'($urandom);
            s.adc_humidity    = 16'($urandom);
        end
        return s;
    endfunction

    // Directed corners of the raw fields plus a mid-scale set
    task automatic send_corners();
        send_sample('{20'd0, 20'd0, 16'd0});
        send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_sample('{20'd0, 20'hFFFFF, 16'd0});
        send_sample('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_sample('{20'd415148, 20'd519888, 16'd30000});
    endtask

    task automatic run_phase(int count);
        send_corners();
        repeat (count) send_sample(rand_sample());
        drain();
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = bsc_pkg::CFG_TEMP;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: zero pressure divisor, invalid pressure
        run_phase(80);

        // typical calibration
        load_coeffs(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, TYP_HUM);
        run_phase(350);

        // large positive temperature gain: saturate high
        load_coeffs({16'd0, 16'h7FFF, 16'h7FFF, 16'd0}, TYP_PA, TYP_PB, TYP_PC, TYP_HUM);
        run_phase(60);

        // large negative gain and extreme pressure / humidity coefficients
        load_coeffs({16'd0, 16'h8000, 16'h8000, 16'hFFFF},
                    {16'd0, 16'h8000, 16'h7FFF, 16'hFFFF},
                    {16'd0, 16'h7FFF, 16'h8000, 16'h7FFF},
                    {16'd0, 16'h8000, 16'h7FFF, 16'h8000},
                    64'h80_7FF_800_FF_7FFF_FF);
        run_phase(60);

        // all ones, upper bits beyond 48 must be dropped
        load_coeffs('1, '1, '1, '1, '1);
        run_phase(60);

        // random calibrations
        repeat (4) begin
            load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
            run_phase(100);
        end

        // typical again; writes to an unused index must change nothing
        load_coeffs(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, TYP_HUM);
        write_coeff(CFG_UNUSED, {$urandom, $urandom});
        write_coeff(CFG_UNUSED_LO, '1);
        write_coeff(CFG_UNUSED_MID, {$urandom, $urandom});
        run_phase(150);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("PASS barometric_sensor_compensation_top");
        end else begin
            $display("FAIL barometric_sensor_compensation_top");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("FAIL barometric_sensor_compensation_top");
        $finish;
    end

endmodule
